[sv/lkv_pkg.sv]
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types and codes of the lru key/value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned CapW  = 5;

  // request codes
  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  // contents of one position of the recency stack
  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] value;
  } lkv_entry_t;

endpackage : lkv_pkg

`default_nettype wire

[sv/lkv_cell.sv]
// ----------------------------------------------------------------------------
// lkv_cell
// one position of the recency stack: holds an entry, compares it against the
// incoming key and takes over its neighbour's entry on a shift
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell
  import lkv_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire logic [KeyW-1:0] key_i,
  input  wire logic            shift_i,
  input  wire lkv_entry_t      prev_i,
  output lkv_entry_t           entry_o,
  output logic                 match_o
);

  logic       valid_q, valid_d;
  logic       match_q, match_d;
  lkv_entry_t entry_q, entry_d;

  always_comb begin
    valid_d = shift_i ? prev_i.valid : valid_q;
    match_d = load_i ? (valid_q && (entry_q.key == key_i)) : match_q;
    entry_d = shift_i ? prev_i : entry_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_comb begin
    entry_o       = entry_q;
    entry_o.valid = valid_q;
    match_o       = match_q;
  end

endmodule : lkv_cell

`default_nettype wire

[sv/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key/value store kept as a recency stack of cells
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  --------------------------
//  in       sink       in_valid_i / in_ready_o   opcode_i, key_i, value_i
//  out      source     out_valid_o / out_ready_i hit_o, data_o
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_capacity_i
//
//  on a request, in the accepting cycle every cell compares the key in
//  parallel and registers its match; then, while busy, the stack shifts by
//  one position up to the hit (or insert) position (a get miss leaves the
//  stack as it is) and a get result is loaded into the output register
//  this completion step holds while a get result cannot enter a full output
//  register; a put never waits on the output
//  reset empties the stack (cell valid flags cleared) and sets capacity to 16
//
`default_nettype none

module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int unsigned MaxEntries = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // request transactions
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             opcode_i,
  input  wire logic [KeyW-1:0]  key_i,
  input  wire logic [DataW-1:0] value_i,
  // result transactions
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  hit_o,
  output logic [DataW-1:0]      data_o,
  // capacity register
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CapW-1:0]  cfg_capacity_i
);

  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  // control state
  logic            busy_q, busy_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CapW-1:0] capacity_q, capacity_d;
  logic            out_valid_q, out_valid_d;
  // registered request, payload only
  logic             op_q;
  logic [KeyW-1:0]  key_q;
  logic [DataW-1:0] value_q;
  logic             hit_q, hit_d;
  logic [DataW-1:0] data_q, data_d;

  logic       in_fire, finish;
  logic       any_hit, do_shift, full;
  logic [IdxW-1:0] hit_pos, ins_pos, shift_pos;
  logic [DataW-1:0] hit_value;
  logic [CntW-1:0]  cap_eff;
  lkv_entry_t       head_entry;

  lkv_entry_t            entries [MaxEntries];
  logic [MaxEntries-1:0] match;
  logic [MaxEntries-1:0] shift_en;

  assign in_ready_o  = !busy_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // the busy request completes unless a get result has nowhere to go
  assign finish = busy_q && !((op_q == OpGet) && out_valid_q && !out_ready_i);

  // effective capacity: zero counts as one, saturated at the stack depth
  always_comb begin
    if (capacity_q == '0) begin
      cap_eff = CntW'(1);
    end else if (32'(capacity_q) > 32'(MaxEntries)) begin
      cap_eff = CntW'(MaxEntries);
    end else begin
      cap_eff = CntW'(capacity_q);
    end
  end

  assign full = (32'(count_q) >= 32'(cap_eff));

  // hit position and value from the registered one-hot match vector
  always_comb begin
    any_hit   = |match;
    hit_pos   = '0;
    hit_value = '0;
    for (int p = 0; p < MaxEntries; p++) begin
      if (match[p]) begin
        hit_pos   = hit_pos | IdxW'(p);
        hit_value = hit_value | entries[p].value;
      end
    end
  end

  // new key goes in at the first free position, or replaces the least recent
  always_comb begin
    if (full) begin
      ins_pos = IdxW'(count_q - CntW'(1));
    end else begin
      ins_pos = IdxW'(count_q);
    end
  end

  assign shift_pos = any_hit ? hit_pos : ins_pos;
  assign do_shift  = finish && (any_hit || (op_q == OpPut));

  // entry that becomes most recent
  always_comb begin
    head_entry.valid = 1'b1;
    head_entry.key   = key_q;
    head_entry.value = (op_q == OpPut) ? value_q : hit_value;
  end

  // the stack: position 0 is the most recent
  for (genvar p = 0; p < MaxEntries; p++) begin : g_cell
    assign shift_en[p] = do_shift && (IdxW'(p) <= shift_pos);

    if (p == 0) begin : g_head
      lkv_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .load_i  (in_fire),
        .key_i   (key_i),
        .shift_i (shift_en[p]),
        .prev_i  (head_entry),
        .entry_o (entries[p]),
        .match_o (match[p])
      );
    end else begin : g_body
      lkv_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .load_i  (in_fire),
        .key_i   (key_i),
        .shift_i (shift_en[p]),
        .prev_i  (entries[p-1]),
        .entry_o (entries[p]),
        .match_o (match[p])
      );
    end
  end

  always_comb begin
    busy_d      = busy_q;
    count_d     = count_q;
    capacity_d  = capacity_q;
    out_valid_d = out_valid_q;
    hit_d       = hit_q;
    data_d      = data_q;

    if (cfg_valid_i && cfg_ready_o) begin
      capacity_d = cfg_capacity_i;
    end

    // output register drains independently of the stack
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_fire) begin
      busy_d = 1'b1;
    end

    if (finish) begin
      busy_d = 1'b0;
      if (op_q == OpGet) begin
        out_valid_d = 1'b1;
        hit_d       = any_hit;
        data_d      = any_hit ? hit_value : '1;
      end else if (!any_hit && !full) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      capacity_q  <= CapW'(16);
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      count_q     <= count_d;
      capacity_q  <= capacity_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= opcode_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    hit_q  <= hit_d;
    data_q <= data_d;
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign data_o      = data_q;

endmodule : lru_key_value_cache

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the lru key/value cache against a predictor of its recency stack
// ----------------------------------------------------------------------------
//
// a directed part covers the empty store, key and value extremes, updates,
// misses and the capacity corners (zero, saturation, lowered below the
// occupied count); a random part then runs phases of traffic over shrinking
// and growing capacities with random idling on both channels
// every lookup transaction is predicted at acceptance and compared with the
// oldest pending result

module testbench;
  import lkv_pkg::*;

  localparam int unsigned MaxEntries  = 16;
  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned DrainCycles = 4;   // a put gives no result but still keeps the cache busy
  localparam int unsigned PoolSize    = 24;
  localparam int unsigned PhaseItems  = 132;

  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] data;
  } lookup_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             opcode_i;
  logic [KeyW-1:0]  key_i;
  logic [DataW-1:0] value_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             hit_o;
  logic [DataW-1:0] data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CapW-1:0]  cfg_capacity_i;

  // predictor state: slot contents, recency order (position 0 most recent)
  logic [KeyW-1:0]  model_key [MaxEntries];
  logic [DataW-1:0] model_val [MaxEntries];
  int unsigned      model_order [MaxEntries];
  int unsigned      model_count;
  logic [CapW-1:0]  model_cap;

  lookup_result_t   pending_lookups [$];
  logic [KeyW-1:0]  key_pool [PoolSize];

  bit               idle_on = 1'b1;
  int unsigned      mismatches;
  int unsigned      results_checked;
  int unsigned      requests_sent;
  int unsigned      lookup_hits;
  int unsigned      lookup_misses;
  int unsigned      cap_writes;

  lru_key_value_cache #(
    .MaxEntries(MaxEntries)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .data_o        (data_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_capacity_i(cfg_capacity_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // zero behaves as one, anything above the stack depth saturates
  function automatic int unsigned usable_entries();
    if (model_cap == 0) return 1;
    if (model_cap > MaxEntries) return MaxEntries;
    return int'(model_cap);
  endfunction

  // position of the key among occupied entries, model_count on a miss
  function automatic int unsigned recency_position(logic [KeyW-1:0] key);
    for (int unsigned p = 0; p < model_count; p++) begin
      if (model_key[model_order[p]] == key) return p;
    end
    return model_count;
  endfunction

  function automatic void make_most_recent(int unsigned pos);
    int unsigned slot;
    slot = model_order[pos];
    for (int unsigned p = pos; p > 0; p--) model_order[p] = model_order[p - 1];
    model_order[0] = slot;
  endfunction

  function automatic void cache_model_apply(logic op, logic [KeyW-1:0] key,
                                            logic [DataW-1:0] val);
    int unsigned    pos;
    int unsigned    slot;
    lookup_result_t res;
    pos = recency_position(key);
    if (op == OpGet) begin
      if (pos < model_count) begin
        slot     = model_order[pos];
        res.hit  = 1'b1;
        res.data = model_val[slot];
        make_most_recent(pos);
        lookup_hits++;
      end else begin
        res.hit  = 1'b0;
        res.data = '1;
        lookup_misses++;
      end
      pending_lookups = {pending_lookups, res};
      return;
    end
    // put on a present key: update in place
    if (pos < model_count) begin
      model_val[model_order[pos]] = val;
      make_most_recent(pos);
      return;
    end
    // new key: reuse the least recent slot when full, else take a free one
    if (model_count >= usable_entries()) begin
      pos = model_count - 1;
    end else begin
      pos = model_count;
      model_count++;
    end
    slot            = model_order[pos];
    model_key[slot] = key;
    model_val[slot] = val;
    make_most_recent(pos);
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // one request transaction; called and returns at a rising edge
  task automatic send_request(input logic op, input logic [KeyW-1:0] key,
                              input logic [DataW-1:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    key_i      <= key;
    value_i    <= val;
    // ready is looked at mid-cycle, the transaction happens at the next edge
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    requests_sent++;
    cache_model_apply(op, key, val);
  endtask

  // drop the request channel and let every pending result drain
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] cap);
    drain_block();
    cfg_capacity_i <= cap;
    cfg_valid_i    <= 1'b1;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    model_cap = cap;
    cap_writes++;
  endtask

  // result side back-pressure, in bursts
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) out_ready_i <= 1'b0;
      else out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // result checking: sampled mid-cycle, the transaction completes at the next edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : check_results
    lookup_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      results_checked++;
      if (pending_lookups.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with no lookup pending: hit %b data %h", $realtime, hit_o,
                   data_o);
        mismatches++;
      end else begin
        want = pending_lookups.pop_front();
        if (hit_o !== want.hit || data_o !== want.data) begin
          if (mismatches < 10)
            $display("%0t: lookup result wrong: hit exp %b got %b, data exp %h got %h",
                     $realtime, want.hit, hit_o, want.data, data_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty store, key and value extremes, update in place, ignored value on get
  task automatic test_empty_and_extremes();
    send_request(OpGet, 32'h0000_0000, 32'h0000_0000);
    send_request(OpPut, 32'h8000_0000, 32'h7fff_ffff);
    send_request(OpPut, 32'h7fff_ffff, 32'h8000_0000);
    send_request(OpPut, 32'hffff_ffff, 32'h0000_0000);
    send_request(OpPut, 32'h0000_0000, 32'hffff_ffff);
    send_request(OpGet, 32'h8000_0000, 32'hffff_ffff);
    send_request(OpGet, 32'h7fff_ffff, 32'h0000_0000);
    send_request(OpGet, 32'hffff_ffff, 32'h5555_5555);
    send_request(OpGet, 32'h0000_0000, 32'haaaa_aaaa);
    send_request(OpPut, 32'h0000_0000, 32'h5a5a_a5a5);
    send_request(OpGet, 32'h0000_0000, 32'hffff_ffff);
    send_request(OpGet, 32'h0000_0001, 32'h0000_0000);
  endtask

  // capacity lowered under the occupied count, zero, and above the depth
  task automatic test_capacity_corners();
    write_capacity(CapW'(1));
    send_request(OpPut, 32'h0000_1234, 32'h1111_2222);
    send_request(OpGet, 32'h8000_0000, 32'h0000_0000);
    send_request(OpGet, 32'h0000_1234, 32'h0000_0000);
    write_capacity(CapW'(0));
    send_request(OpPut, 32'hdead_beef, 32'hcafe_f00d);
    send_request(OpGet, 32'h0000_1234, 32'h0000_0000);
    send_request(OpGet, 32'hdead_beef, 32'h0000_0000);
    write_capacity(CapW'(31));
    send_request(OpPut, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
    send_request(OpPut, 32'hf0f0_f0f0, 32'h0f0f_0f0f);
    send_request(OpGet, 32'h0f0f_0f0f, 32'h0000_0000);
  endtask

  // phases of mixed traffic, mostly over a small key pool so hits and evictions occur
  task automatic test_random_traffic();
    logic [CapW-1:0]  caps [9];
    int unsigned      span;
    int unsigned      segment_left;
    logic             op;
    logic [KeyW-1:0]  key;
    caps = '{CapW'(16), CapW'(3), CapW'(1), CapW'(31), CapW'(0), CapW'(8),
             CapW'($urandom_range(2, 15)), CapW'(5), CapW'(16)};
    for (int ph = 0; ph < 9; ph++) begin
      write_capacity(caps[ph]);
      for (int i = 0; i < PoolSize; i++) key_pool[i] = $urandom;
      span         = usable_entries() + 4;
      segment_left = 0;
      for (int n = 0; n < PhaseItems; n++) begin
        // no idling at all in the closing phase
        if (ph == 8) begin
          idle_on = 1'b0;
        end else if (segment_left == 0) begin
          idle_on      = ($urandom_range(0, 2) != 0);
          segment_left = $urandom_range(20, 60);
        end else begin
          segment_left--;
        end
        op  = $urandom_range(0, 1) ? OpPut : OpGet;
        key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, span - 1)] : $urandom;
        send_request(op, key, $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = OpGet;
    key_i          = '0;
    value_i        = '0;
    cfg_valid_i    = 1'b0;
    cfg_capacity_i = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      model_key[i]   = '0;
      model_val[i]   = '0;
      model_order[i] = i;
    end
    model_count = 0;
    model_cap   = CapW'(16);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_extremes();
    test_capacity_corners();
    test_random_traffic();

    // bounded wait for the last results
    in_valid_i <= 1'b0;
    for (int w = 0; w < 2000 && pending_lookups.size() != 0; w++) @(posedge clk_i);
    repeat (DrainCycles * 4) @(posedge clk_i);
    if (pending_lookups.size() != 0) begin
      $display("%0d lookup results never arrived", pending_lookups.size());
      mismatches += pending_lookups.size();
    end

    $display("ran %0d requests over %0d capacity settings, lookups: %0d hits, %0d misses",
             requests_sent, cap_writes, lookup_hits, lookup_misses);
    $display("%0d results compared, %0d mismatched", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[lru_key_value_cache.f]
sv/lkv_pkg.sv
sv/lkv_cell.sv
sv/lru_key_value_cache.sv
dv/testbench.sv
